@@ rtl/core/cia_pkg.sv @@
// Package for the checked integer ALU: operation codes, pipeline item types
// and the width, extension, range and division-step helpers.
// No dependencies.
package cia_pkg;

  localparam int unsigned XLEN      = 64;
  localparam int unsigned DIV_STEPS = XLEN;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_REM = 4'd4,
    OP_AND = 4'd5,
    OP_OR  = 4'd6,
    OP_XOR = 4'd7,
    OP_SHL = 4'd8,
    OP_SHR = 4'd9
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            sg;
    logic [1:0]      wc;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
  } in_t;

  typedef struct packed {
    op_e             op;
    logic            sg;
    logic [1:0]      wc;
    logic            an;
    logic            bn;
    logic            canon;
    logic            bzero;
    logic            early_ok;
    logic [XLEN-1:0] early_r;
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] quo;
    logic [XLEN-1:0] dvs;
  } dv_t;

  typedef struct packed {
    dv_t             d;
    logic [XLEN-1:0] ll;
    logic [XLEN-1:0] lh;
    logic [XLEN-1:0] hl;
    logic [XLEN-1:0] hh;
  } mul_t;

  function automatic logic [6:0] width_of(input logic [1:0] wc);
    return 7'd8 << wc;
  endfunction

  function automatic logic [XLEN-1:0] wmask(input logic [1:0] wc);
    logic [XLEN-1:0] m;
    case (wc)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [XLEN-1:0] sext(input logic [XLEN-1:0] x, input logic [1:0] wc);
    logic [XLEN-1:0] r;
    case (wc)
      2'd0:    r = {{56{x[7]}}, x[7:0]};
      2'd1:    r = {{48{x[15]}}, x[15:0]};
      2'd2:    r = {{32{x[31]}}, x[31:0]};
      default: r = x;
    endcase
    return r;
  endfunction

  function automatic logic [XLEN-1:0] sign_lim(input logic [1:0] wc);
    logic [XLEN-1:0] r;
    r = ~(wmask(wc) >> 1);
    return r & wmask(wc);
  endfunction

  // magnitude with sign fits the signed range of the width
  function automatic logic fits(input logic [XLEN-1:0] mag, input logic neg,
                                input logic [1:0] wc);
    return neg ? (mag <= sign_lim(wc)) : (mag < sign_lim(wc));
  endfunction

  function automatic dv_t div_step(input dv_t d);
    dv_t         r;
    logic [XLEN:0] trial;
    logic [XLEN:0] diff;
    logic          bit_q;
    r     = d;
    trial = {d.rem, d.quo[XLEN-1]};
    diff  = trial - {1'b0, d.dvs};
    bit_q = (trial >= {1'b0, d.dvs});
    r.rem = bit_q ? diff[XLEN-1:0] : trial[XLEN-1:0];
    r.quo = {d.quo[XLEN-2:0], bit_q};
    return r;
  endfunction

endpackage

@@ rtl/core/cia_early.sv @@
// Front stage of the checked integer ALU: operand checks, add, subtract,
// bitwise and shift results, multiply partial products and divider set-up.
// Depends on cia_pkg.
module cia_early import cia_pkg::*; (
  input  in_t  item_i,
  output mul_t early_o
);

  logic [XLEN-1:0] m, a, b, am, bm, r, v, carrier, cand, chk;
  logic [XLEN:0]   sum;
  logic            canon_a, canon_b, an, bn, ok, cnt_ok;
  logic [5:0]      c;
  logic [6:0]      w;
  logic signed [XLEN-1:0] chk_s, shr_s;

  always_comb begin
    m  = wmask(item_i.wc);
    w  = width_of(item_i.wc);
    a  = item_i.a;
    b  = item_i.b;
    canon_a = item_i.sg ? (a == sext(a, item_i.wc)) : ((a & ~m) == '0);
    canon_b = item_i.sg ? (b == sext(b, item_i.wc)) : ((b & ~m) == '0);
    an = item_i.sg & a[XLEN-1];
    bn = item_i.sg & b[XLEN-1];
    am = an ? (~a + 64'd1) : a;
    bm = bn ? (~b + 64'd1) : b;
    v       = a & m;
    carrier = item_i.sg ? sext(v, item_i.wc) : v;
    cnt_ok  = (b < {57'd0, w});
    c       = b[5:0];
    cand    = (v << c) & m;
    chk_s   = $signed(sext(cand, item_i.wc)) >>> c;
    shr_s   = $signed(carrier) >>> c;
    chk     = item_i.sg ? ($unsigned(chk_s) & m) : (cand >> c);
    sum     = '0;
    r       = '0;
    ok      = 1'b0;
    case (item_i.op)
      OP_ADD: begin
        if (item_i.sg) begin
          r  = a + b;
          ok = canon_a & canon_b
               & ~((a[XLEN-1] ^ r[XLEN-1]) & (b[XLEN-1] ^ r[XLEN-1]))
               & (r == sext(r, item_i.wc));
        end else begin
          sum = {1'b0, a} + {1'b0, b};
          r   = sum[XLEN-1:0];
          ok  = canon_a & canon_b & (sum <= {1'b0, m});
        end
      end
      OP_SUB: begin
        r = a - b;
        if (item_i.sg) begin
          ok = canon_a & canon_b
               & ~((a[XLEN-1] ^ b[XLEN-1]) & (a[XLEN-1] ^ r[XLEN-1]))
               & (r == sext(r, item_i.wc));
        end else begin
          ok = canon_a & canon_b & (a >= b);
        end
      end
      OP_AND: begin
        r  = a & b & m;
        ok = 1'b1;
      end
      OP_OR: begin
        r  = (a | b) & m;
        ok = 1'b1;
      end
      OP_XOR: begin
        r  = (a ^ b) & m;
        ok = 1'b1;
      end
      OP_SHL: begin
        r  = cand;
        ok = (a == carrier) & cnt_ok & (chk == v);
      end
      OP_SHR: begin
        r  = item_i.sg ? ($unsigned(shr_s) & m) : (v >> c);
        ok = (a == carrier) & cnt_ok;
      end
      default: begin
        r  = '0;
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    early_o.d.op       = item_i.op;
    early_o.d.sg       = item_i.sg;
    early_o.d.wc       = item_i.wc;
    early_o.d.an       = an;
    early_o.d.bn       = bn;
    early_o.d.canon    = canon_a & canon_b;
    early_o.d.bzero    = (b == '0);
    early_o.d.early_ok = ok;
    early_o.d.early_r  = r;
    early_o.d.rem      = '0;
    early_o.d.quo      = am;
    early_o.d.dvs      = bm;
    early_o.ll         = am[31:0] * bm[31:0];
    early_o.lh         = am[31:0] * bm[63:32];
    early_o.hl         = am[63:32] * bm[31:0];
    early_o.hh         = am[63:32] * bm[63:32];
  end

endmodule

@@ rtl/core/checked_integer_alu.sv @@
// Checked integer ALU top level: input register, front stage, 64-stage
// restoring divider pipeline that carries all items, output register.
// Depends on cia_pkg and cia_early.
// Throughput: one item per cycle; busy_o stays low, the 64 divider stages set depth.
// Reset clears all valid bits; items in flight are dropped.
module checked_integer_alu import cia_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [3:0]      mode_i,
  input  logic            signed_mode_i,
  input  logic [1:0]      width_code_i,
  input  logic [XLEN-1:0] left_operand_i,
  input  logic [XLEN-1:0] right_operand_i,
  output logic            done_o,
  output logic [XLEN-1:0] result_value_o,
  output logic            ok_o
);

  in_t                 s1_q;
  logic                s1_vld_q;
  mul_t                s2_d, s2_q;
  logic                s2_vld_q;
  dv_t                 dv_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_vld_q;
  dv_t                 st0_d;
  logic [XLEN-1:0]     mid, hi, lo, res_d, fin_r;
  logic [65:0]         mid_w;
  logic                neg, fin_neg, fin_ok, done_q, ok_q;
  logic [XLEN-1:0]     res_q;
  dv_t                 last;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      dv_vld_q <= '0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= start_i & ~busy_o;
      s2_vld_q <= s1_vld_q;
      dv_vld_q <= {dv_vld_q[DIV_STEPS-2:0], s2_vld_q};
      done_q   <= dv_vld_q[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q.op <= op_e'(mode_i);
    s1_q.sg <= signed_mode_i;
    s1_q.wc <= width_code_i;
    s1_q.a  <= left_operand_i;
    s1_q.b  <= right_operand_i;
    s2_q    <= s2_d;
  end

  cia_early u_early (
    .item_i  (s1_q),
    .early_o (s2_d)
  );

  // finish the multiply in the first divider stage
  always_comb begin
    mid_w = {34'd0, s2_q.ll[63:32]} + {34'd0, s2_q.lh[31:0]} + {34'd0, s2_q.hl[31:0]};
    mid   = {30'd0, mid_w[65:32]};
    lo    = {mid_w[31:0], s2_q.ll[31:0]};
    hi    = s2_q.hh + {32'd0, s2_q.lh[63:32]} + {32'd0, s2_q.hl[63:32]} + mid;
    neg   = (s2_q.d.an ^ s2_q.d.bn) & (lo != '0);
    st0_d = s2_q.d;
    if (s2_q.d.op == OP_MUL) begin
      st0_d.early_r  = neg ? (~lo + 64'd1) : lo;
      st0_d.early_ok = s2_q.d.canon & (hi == '0) &
                       (s2_q.d.sg ? fits(lo, neg, s2_q.d.wc) : (lo <= wmask(s2_q.d.wc)));
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    if (i == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        dv_q[i] <= div_step(st0_d);
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        dv_q[i] <= div_step(dv_q[i-1]);
      end
    end
  end

  always_comb begin
    last    = dv_q[DIV_STEPS-1];
    fin_r   = last.early_r;
    fin_ok  = last.early_ok;
    fin_neg = 1'b0;
    case (last.op)
      OP_DIV: begin
        fin_neg = (last.an ^ last.bn) & (last.quo != '0);
        fin_r   = fin_neg ? (~last.quo + 64'd1) : last.quo;
        fin_ok  = last.canon & ~last.bzero & (~last.sg | fits(last.quo, fin_neg, last.wc));
      end
      OP_REM: begin
        fin_neg = last.an & (last.rem != '0);
        fin_r   = fin_neg ? (~last.rem + 64'd1) : last.rem;
        fin_ok  = last.canon & ~last.bzero & (~last.sg | fits(last.rem, fin_neg, last.wc));
      end
      default: begin
        fin_r  = last.early_r;
        fin_ok = last.early_ok;
      end
    endcase
    if (!fin_ok) begin
      res_d = '0;
    end else if (last.sg) begin
      res_d = sext(fin_r, last.wc);
    end else begin
      res_d = fin_r & wmask(last.wc);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    ok_q  <= fin_ok;
  end

  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign ok_o           = ok_q;

endmodule

@@ rtl/core/cia_checker.sv @@
// Port checker for the checked integer ALU, bound to the top level.
// Depends on nothing beyond the top level's ports.
module cia_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [63:0] result_value_o,
  input logic        ok_o
);

  localparam int unsigned Lat = 67;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !ok_o |-> result_value_o == 64'd0)
    else $error("failed item carries a value");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Lat))
    else $error("result without a matching item");

endmodule

bind checked_integer_alu cia_checker u_cia_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .result_value_o (result_value_o),
  .ok_o           (ok_o)
);

@@ verif/checked_integer_alu_test.sv @@
// Self-checking testbench for the checked integer ALU: a directed table of items
// followed by random bursts, every result compared against its table row or a behavioural predictor.
// Depends on cia_pkg and the checked_integer_alu RTL.
module checked_integer_alu_test;
  import cia_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LATENCY    = 67;
  localparam int unsigned WATCHDOG   = 2000;
  localparam int unsigned RAND_ITEMS = 1700;

  typedef struct {
    logic [3:0]  mode;
    logic        sg;
    logic [1:0]  wc;
    logic [63:0] a;
    logic [63:0] b;
    logic        known;
    logic [63:0] r;
    logic        ok;
  } row_t;

  typedef struct {
    logic [63:0] r;
    logic        ok;
  } res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  mode = '0;
  logic        sg = 1'b0;
  logic [1:0]  wc = '0;
  logic [63:0] a = '0;
  logic [63:0] b = '0;
  logic        done;
  logic [63:0] res;
  logic        ok;

  res_t        pending_q[$];
  row_t        table_q[$];
  int unsigned fails = 0;
  int unsigned idle_cycles = 0;

  checked_integer_alu dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .mode_i(mode), .signed_mode_i(sg), .width_code_i(wc),
    .left_operand_i(a), .right_operand_i(b),
    .done_o(done), .result_value_o(res), .ok_o(ok)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] mask_w(input logic [1:0] c);
    return (c == 2'd3) ? '1 : ((64'd1 << (8 << c)) - 64'd1);
  endfunction

  function automatic logic [63:0] ext_w(input logic [63:0] x, input logic [1:0] c);
    int unsigned w;
    logic [63:0] m;
    w = 8 << c;
    m = mask_w(c);
    if (w == 64) return x;
    return x[w-1] ? ((x & m) | ~m) : (x & m);
  endfunction

  function automatic res_t alu_predict(input logic [3:0] op, input logic s,
                                       input logic [1:0] c, input logic [63:0] x,
                                       input logic [63:0] y);
    res_t          o;
    int unsigned   w;
    logic [63:0]   m, v, cand;
    logic signed [63:0] sv;
    logic signed [129:0] ex, sx, sy, lo_b, hi_b;
    o.r = '0;
    o.ok = 1'b0;
    w = 8 << c;
    m = mask_w(c);
    if (op <= OP_REM) begin
      if (s) begin
        sx = $signed({{66{x[63]}}, x});
        sy = $signed({{66{y[63]}}, y});
        lo_b = -($signed(130'd1) <<< (w - 1));
        hi_b = ($signed(130'd1) <<< (w - 1)) - 1;
        if (x != ext_w(x, c) || y != ext_w(y, c)) return o;
      end else begin
        sx = $signed({66'd0, x});
        sy = $signed({66'd0, y});
        lo_b = 0;
        hi_b = $signed({66'd0, m});
        if (x > m || y > m) return o;
      end
      case (op)
        OP_ADD: ex = sx + sy;
        OP_SUB: ex = sx - sy;
        OP_MUL: ex = sx * sy;
        OP_DIV: begin
          if (y == 0) return o;
          ex = sx / sy;
        end
        default: begin
          if (y == 0) return o;
          ex = sx % sy;
        end
      endcase
      if (ex < lo_b || ex > hi_b) return o;
      o.r = ex[63:0];
      o.ok = 1'b1;
    end else if (op <= OP_XOR) begin
      case (op)
        OP_AND:  o.r = x & y & m;
        OP_OR:   o.r = (x | y) & m;
        default: o.r = (x ^ y) & m;
      endcase
      o.ok = 1'b1;
    end else if (op <= OP_SHR) begin
      v = x & m;
      if (x != (s ? ext_w(v, c) : v) || y >= w) return o;
      if (op == OP_SHL) begin
        cand = (v << y) & m;
        sv = $signed(ext_w(cand, c)) >>> y;
        if (s ? (($unsigned(sv) & m) != v) : ((cand >> y) != v)) return o;
      end else begin
        sv = $signed(ext_w(v, c)) >>> y;
        cand = s ? ($unsigned(sv) & m) : (v >> y);
      end
      o.r = cand;
      o.ok = 1'b1;
    end
    if (o.ok) o.r = s ? ext_w(o.r, c) : (o.r & m);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fails++;
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst_n && done) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", res, '0);
      end else begin
        e = pending_q.pop_front();
        if (ok !== e.ok) report_mismatch("ok", ok, e.ok);
        if (res !== e.r) report_mismatch("result_value", res, e.r);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("checked_integer_alu_test: FAIL");
      $finish;
    end
  end

  task automatic send(input row_t t);
    res_t p;
    mode  <= t.mode;
    sg    <= t.sg;
    wc    <= t.wc;
    a     <= t.a;
    b     <= t.b;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = alu_predict(t.mode, t.sg, t.wc, t.a, t.b);
    if (t.known && (p.r !== t.r || p.ok !== t.ok))
      report_mismatch("table row", p.r, t.r);
    if (t.known) begin
      p.r = t.r;
      p.ok = t.ok;
    end
    pending_q.push_back(p);
  endtask

  function automatic row_t mk(input logic [3:0] op, input logic s, input logic [1:0] c,
                              input logic [63:0] x, input logic [63:0] y,
                              input logic k, input logic [63:0] r, input logic o);
    row_t t;
    t.mode = op; t.sg = s; t.wc = c; t.a = x; t.b = y;
    t.known = k; t.r = r; t.ok = o;
    return t;
  endfunction

  function automatic logic [63:0] rand_operand(input logic s, input logic [1:0] c);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = 64'd0;
      1: v = s ? ext_w(64'd1 << ((8 << c) - 1), c) : mask_w(c);
      2: v = s ? ext_w(mask_w(c) >> 1, c) : 64'd1;
      3: v = s ? '1 : v & 64'hF;
      4: ;
      default: v = s ? ext_w(v >> $urandom_range(0, 63), c)
                     : (v >> $urandom_range(0, 63)) & mask_w(c);
    endcase
    return v;
  endfunction

  initial begin
    row_t t;
    int unsigned n, burst;
    logic drained;
    drained = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    table_q.push_back(mk(OP_ADD, 1, 0, 64'h7F, 64'h1, 1, 0, 0));
    table_q.push_back(mk(OP_ADD, 0, 0, 64'hFF, 64'h0, 1, 64'hFF, 1));
    table_q.push_back(mk(OP_ADD, 0, 3, '1, 64'h1, 1, 0, 0));
    table_q.push_back(mk(OP_SUB, 0, 1, 64'h0, 64'h1, 1, 0, 0));
    table_q.push_back(mk(OP_SUB, 1, 3, 64'h8000_0000_0000_0000, 64'h1, 1, 0, 0));
    table_q.push_back(mk(OP_MUL, 1, 2, 64'hFFFF_FFFF_8000_0000, '1, 1, 0, 0));
    table_q.push_back(mk(OP_MUL, 0, 3, '1, '1, 1, 0, 0));
    table_q.push_back(mk(OP_DIV, 1, 0, 64'hFFFF_FFFF_FFFF_FF80, '1, 1, 0, 0));
    table_q.push_back(mk(OP_DIV, 0, 2, 64'h5, 64'h0, 1, 0, 0));
    table_q.push_back(mk(OP_REM, 1, 3, 64'h8000_0000_0000_0000, '1, 1, 0, 1));
    table_q.push_back(mk(OP_REM, 1, 0, 64'hFFFF_FFFF_FFFF_FFF9, 64'h2, 1, '1, 1));
    table_q.push_back(mk(OP_REM, 0, 1, 64'h7, 64'h0, 1, 0, 0));
    table_q.push_back(mk(OP_ADD, 0, 0, 64'h100, 64'h0, 1, 0, 0));
    table_q.push_back(mk(OP_ADD, 1, 1, 64'h8000, 64'h0, 1, 0, 0));
    table_q.push_back(mk(OP_AND, 1, 0, '1, 64'h80, 1, 64'hFFFF_FFFF_FFFF_FF80, 1));
    table_q.push_back(mk(OP_OR, 0, 1, 64'h1234_0000_0000_00F0, 64'h0F, 1, 64'hFF, 1));
    table_q.push_back(mk(OP_XOR, 0, 3, '1, 64'h0, 1, '1, 1));
    table_q.push_back(mk(OP_SHL, 0, 0, 64'h1, 64'h8, 1, 0, 0));
    table_q.push_back(mk(OP_SHL, 0, 0, 64'h1, 64'h7, 1, 64'h80, 1));
    table_q.push_back(mk(OP_SHL, 1, 0, 64'h1, 64'h7, 1, 0, 0));
    table_q.push_back(mk(OP_SHL, 1, 3, '1, 64'd63, 1, 64'h8000_0000_0000_0000, 1));
    table_q.push_back(mk(OP_SHR, 1, 1, 64'hFFFF_FFFF_FFFF_8000, 64'd15, 1, '1, 1));
    table_q.push_back(mk(OP_SHR, 0, 2, 64'h8000_0000, 64'h1_0000_0000, 1, 0, 0));
    table_q.push_back(mk(4'd15, 1, 3, 64'h5, 64'h5, 1, 0, 0));
    table_q.push_back(mk(OP_MUL, 1, 1, 64'hFFFF_FFFF_FFFF_FFFE, 64'h3, 0, 0, 0));
    foreach (table_q[i]) send(table_q[i]);

    n = 0;
    while (n < RAND_ITEMS) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && n < RAND_ITEMS) begin
        t.sg = $urandom_range(0, 1);
        t.wc = $urandom_range(0, 3);
        t.mode = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 15)
                                               : $urandom_range(0, 9);
        t.a = rand_operand(t.sg, t.wc);
        t.b = rand_operand(t.sg, t.wc);
        if (t.mode >= OP_SHL && $urandom_range(0, 3) != 0)
          t.b = $urandom_range(0, (8 << t.wc) + 1);
        t.known = 1'b0;
        send(t);
        burst--;
        n++;
      end
      if (!drained && n >= RAND_ITEMS / 2) begin
        drained = 1'b1;
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (fails == 0) $display("checked_integer_alu_test: PASS");
    else $display("checked_integer_alu_test: FAIL");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/cia_pkg.sv
rtl/core/cia_early.sv
rtl/core/checked_integer_alu.sv
rtl/core/cia_checker.sv
verif/checked_integer_alu_test.sv
